// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/ort_pkg.sv -----
// ----------------------------------------------------------------------------
// ort_pkg
// shared types, codes and defaults of the outstanding request tracker
// ----------------------------------------------------------------------------
package ort_pkg;

    localparam int ORT_SLOTS    = 64;
    localparam int ORT_TAG_BITS = 64;

    localparam int FIELD_TAG_W  = 64;
    localparam int SLOT_IDX_W   = 6;
    localparam int COUNT_W      = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_TRACK_ENABLE = 3'd0;

    // request type codes
    localparam logic [1:0] REQ_TRACK  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_FREE   = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [FIELD_TAG_W-1:0] request_tag;
        logic [FIELD_TAG_W-1:0] header_tag;
    } ort_in_t;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_IDX_W-1:0]     slot_index;
        logic [COUNT_W-1:0]        total_count;
        logic signed [COUNT_W-1:0] outstanding_count;
    } ort_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming word
        logic match;   // register the per-slot match vector
        logic commit;  // update table, counters and the result register
    } ort_cmd_t;

endpackage

// ----- sv/ort_ctrl.sv -----
// ----------------------------------------------------------------------------
// ort_ctrl
// sequencing of load, match and commit, plus the result valid flag
// ----------------------------------------------------------------------------
module ort_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ort_pkg::ort_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   commit;
    logic   load;

    // commit once the result register is free or being drained
    assign commit  = (state_reg == ST_WRITE) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE) || commit;
    assign load    = s_valid && s_ready;

    assign cmd.load   = load;
    assign cmd.match  = (state_reg == ST_MATCH);
    assign cmd.commit = commit;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (commit) state_next = load ? ST_MATCH : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/ort_dpath.sv -----
// ----------------------------------------------------------------------------
// ort_dpath
// slot table with per-slot tag compare, lowest-slot select and counters
// ----------------------------------------------------------------------------
module ort_dpath #(
    parameter int SLOTS    = ort_pkg::ORT_SLOTS,
    parameter int TAG_BITS = ort_pkg::ORT_TAG_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ort_pkg::ort_cmd_t cmd,
    input  logic              track_enable,
    input  ort_pkg::ort_in_t  s_word,
    output ort_pkg::ort_out_t m_word
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [1:0]                   in_type_reg;
    logic [TAG_BITS-1:0]          in_rtag_reg;
    logic [TAG_BITS-1:0]          in_htag_reg;

    logic [SLOTS-1:0]             valid_reg, valid_next;
    logic [TAG_BITS-1:0]          req_tag_reg [SLOTS];
    logic [TAG_BITS-1:0]          hdr_tag_reg [SLOTS];

    logic [SLOTS-1:0]             match_reg, match_next;
    logic [SLOTS-1:0]             first_hot;
    logic                         found;
    logic [IDX_W-1:0]             hit_idx;
    logic                         apply;

    logic [ort_pkg::COUNT_W-1:0]  total_reg, total_next;
    logic [ort_pkg::COUNT_W-1:0]  outst_reg, outst_next;
    ort_pkg::ort_out_t            out_reg, out_next;

    // input capture, tags cut to the stored width
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_type_reg <= s_word.req_type;
            in_rtag_reg <= s_word.request_tag[TAG_BITS-1:0];
            in_htag_reg <= s_word.header_tag[TAG_BITS-1:0];
        end
    end

    // candidate vector: free slots for a track, matching valid slots otherwise
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (in_type_reg == ort_pkg::REQ_TRACK) begin
                match_next[i] = !valid_reg[i];
            end else if (in_type_reg == ort_pkg::REQ_FREE) begin
                match_next[i] = valid_reg[i] && (hdr_tag_reg[i] == in_htag_reg);
            end else begin
                match_next[i] = valid_reg[i] && (req_tag_reg[i] == in_rtag_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.match) match_reg <= match_next;
    end

    // lowest candidate wins
    assign first_hot = match_reg & (~match_reg + SLOTS'(1));
    assign found     = |match_reg;

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (first_hot[i]) hit_idx = hit_idx | IDX_W'(i);
        end
    end

    assign apply = cmd.commit && track_enable;

    always_comb begin
        valid_next = valid_reg;
        total_next = total_reg;
        outst_next = outst_reg;
        if (apply) begin
            case (in_type_reg)
                ort_pkg::REQ_TRACK: begin
                    valid_next = valid_reg | first_hot;
                    total_next = total_reg + ort_pkg::COUNT_W'(1);
                    outst_next = outst_reg + ort_pkg::COUNT_W'(1);
                end
                ort_pkg::REQ_UPDATE: begin
                    // header rewrite only, handled in the tag store
                    valid_next = valid_reg;
                end
                default: begin
                    valid_next = valid_reg & ~first_hot;
                    outst_next = outst_reg - ort_pkg::COUNT_W'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            total_reg <= '0;
            outst_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            total_reg <= total_next;
            outst_reg <= outst_next;
        end
    end

    // tag store, each slot written through its own select line
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (apply && first_hot[i]) begin
                if (in_type_reg == ort_pkg::REQ_TRACK) begin
                    req_tag_reg[i] <= in_rtag_reg;
                    hdr_tag_reg[i] <= in_htag_reg;
                end else if (in_type_reg == ort_pkg::REQ_UPDATE) begin
                    hdr_tag_reg[i] <= in_htag_reg;
                end
            end
        end
    end

    always_comb begin
        out_next.hit               = apply && found;
        out_next.slot_index        = (apply && found) ?
                                     ort_pkg::SLOT_IDX_W'(hit_idx) : '0;
        out_next.total_count       = total_next;
        out_next.outstanding_count = $signed(outst_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) out_reg <= out_next;
    end

    assign m_word = out_reg;

endmodule

// ----- sv/outstanding_request_tracker.sv -----
// ----------------------------------------------------------------------------
// outstanding_request_tracker
// slot table that tracks outstanding requests by request and header tag
// ----------------------------------------------------------------------------
// usage
//   input channel s_valid/s_ready/s_word carries one request word: a type
//   (track, update header, free by header tag, remove by request tag) and two
//   tags. every accepted word yields exactly one result word on
//   m_valid/m_ready/m_word: hit flag, slot index and both counters.
//   track_enable is written through the apb port; while it is zero every word
//   returns hit 0 with the current counts and changes nothing.
// timing
//   a word is captured, all slots are compared in parallel in the next cycle,
//   and once the result register is free or draining the lowest candidate is
//   selected, the table and counters are updated and the result register is
//   loaded. a new word is accepted in the commit cycle, so the next word is
//   taken while the last one commits; the registered compare stage is followed
//   by the select and update stage.
// reset and stalls
//   reset clears all valid bits, both counters and track_enable; stored tags
//   stay undefined until written. when m_ready is low the finished result
//   holds in the output register; the next word is still taken and worked up
//   to the commit stage, where it waits until the result register drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module outstanding_request_tracker #(
    parameter int SLOTS    = ort_pkg::ORT_SLOTS,
    parameter int TAG_BITS = ort_pkg::ORT_TAG_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ort_pkg::ort_in_t                 s_word,
    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output ort_pkg::ort_out_t                m_word,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ort_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ort_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ort_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    ort_pkg::ort_cmd_t cmd;
    logic              track_enable_reg, track_enable_next;
    logic              cfg_write;

    // apb register block: single enable bit, zero wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        track_enable_next = track_enable_reg;
        if (cfg_write && (paddr == ort_pkg::ADDR_TRACK_ENABLE)) begin
            track_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_enable_reg <= 1'b0;
        end else begin
            track_enable_reg <= track_enable_next;
        end
    end

    assign prdata = (paddr == ort_pkg::ADDR_TRACK_ENABLE) ?
                    ort_pkg::APB_DATA_W'(track_enable_reg) : '0;

    // sequencing
    ort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // slot table, compare, select and counters
    ort_dpath #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .track_enable (track_enable_reg),
        .s_word       (s_word),
        .m_word       (m_word)
    );

    // a captured word blocks the input until its commit cycle
    `ASSERT_NEXT(a_accept_then_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // every commit presents a result
    `ASSERT_NEXT(a_commit_shows_result, aclk, aresetn, cmd.commit, m_valid)
    // nothing is hit while tracking is off
    `ASSERT_NEXT(a_disabled_no_hit, aclk, aresetn, cmd.commit && !track_enable_reg,
        !m_word.hit && (m_word.slot_index == '0))
    // match and commit never overlap
    `ASSERT_IMPLIES(a_match_not_commit, aclk, aresetn, cmd.match, !cmd.commit)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the outstanding request tracker: each accepted
// request word runs through a slot table predictor kept in the bench, and
// every result word is compared field by field, in order, with what the
// predictor said; both handshake sides idle at random
// ----------------------------------------------------------------------------
module tb;

    localparam logic [63:0] TAG_MASK =
        (ort_pkg::ORT_TAG_BITS >= 64) ? 64'hffff_ffff_ffff_ffff :
        ((64'd1 << ort_pkg::ORT_TAG_BITS) - 64'd1);
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    // dut ports
    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    ort_pkg::ort_in_t               s_word = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    ort_pkg::ort_out_t              m_word;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ort_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ort_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ort_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // bench copy of the slot table, counters and enable
    bit   [ort_pkg::ORT_SLOTS-1:0]  live_slots;
    logic [63:0]                    slot_rtag [ort_pkg::ORT_SLOTS];
    logic [63:0]                    slot_htag [ort_pkg::ORT_SLOTS];
    logic [31:0]                    tracked_total;
    logic [31:0]                    outstanding_now;
    bit                             tracking_on;

    // result words still owed by the dut, oldest first
    ort_pkg::ort_out_t              pending_results[$];
    int                             fail_count = 0;

    // idle pattern state: each side runs in stretches, some with no idling
    int                             src_run = 0;
    bit                             src_quiet = 1'b0;
    int                             snk_run = 0;
    bit                             snk_quiet = 1'b0;

    // tags that the random traffic keeps reusing so that matches happen
    logic [63:0]                    tag_pool [16];

    outstanding_request_tracker u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // safety net: far beyond the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // cycles to wait before the next word, in stretches of busy and quiet
    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // lowest live slot whose chosen tag equals key, -1 if none
    function automatic int lowest_match(bit by_header, logic [63:0] key);
        for (int s = 0; s < ort_pkg::ORT_SLOTS; s++) begin
            if (live_slots[s] && ((by_header ? slot_htag[s] : slot_rtag[s]) == key))
                return s;
        end
        return -1;
    endfunction

    // apply one request word to the bench table and give the result it causes
    function automatic ort_pkg::ort_out_t track_outcome(ort_pkg::ort_in_t w);
        ort_pkg::ort_out_t r;
        int                slot;
        logic [63:0]       rtag;
        logic [63:0]       htag;
        slot = -1;
        rtag = w.request_tag & TAG_MASK;
        htag = w.header_tag & TAG_MASK;
        if (tracking_on) begin
            case (w.req_type)
                ort_pkg::REQ_TRACK: begin
                    for (int s = 0; s < ort_pkg::ORT_SLOTS; s++) begin
                        if (slot < 0 && !live_slots[s])
                            slot = s;
                    end
                    // a full table still counts the request
                    if (slot >= 0) begin
                        live_slots[slot] = 1'b1;
                        slot_rtag[slot] = rtag;
                        slot_htag[slot] = htag;
                    end
                    tracked_total = tracked_total + 32'd1;
                    outstanding_now = outstanding_now + 32'd1;
                end
                ort_pkg::REQ_UPDATE: begin
                    slot = lowest_match(1'b0, rtag);
                    if (slot >= 0)
                        slot_htag[slot] = htag;
                end
                default: begin
                    // free matches on header tag, remove on request tag
                    slot = lowest_match(w.req_type == ort_pkg::REQ_FREE,
                                        (w.req_type == ort_pkg::REQ_FREE) ? htag : rtag);
                    if (slot >= 0)
                        live_slots[slot] = 1'b0;
                    outstanding_now = outstanding_now - 32'd1;
                end
            endcase
        end
        r.hit = (slot >= 0);
        r.slot_index = (slot >= 0) ? slot[ort_pkg::SLOT_IDX_W-1:0] : '0;
        r.total_count = tracked_total;
        r.outstanding_count = outstanding_now;
        return r;
    endfunction

    // random live slot, -1 when the table is empty
    function automatic int pick_live();
        int s;
        if (live_slots == '0)
            return -1;
        s = $urandom_range(0, ort_pkg::ORT_SLOTS - 1);
        while (!live_slots[s])
            s = (s + 1) % ort_pkg::ORT_SLOTS;
        return s;
    endfunction

    // offer one word; called after the previous word's accepting edge, so valid
    // only drops when the next word comes after a gap
    task automatic send_word(input logic [1:0] kind, input logic [63:0] rtag,
                             input logic [63:0] htag);
        int               gap;
        ort_pkg::ort_in_t w;
        gap = draw_wait(src_run, src_quiet);
        w.req_type = kind;
        w.request_tag = rtag;
        w.header_tag = htag;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(track_outcome(w));
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // apb write: setup then access; only done while the block is idle
    task automatic write_enable(input bit en);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ort_pkg::ADDR_TRACK_ENABLE;
        // only bit 0 counts, the rest is noise
        pwdata <= {31'($urandom_range(0, 32'h7fff_ffff)), en};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracking_on = en;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result side: ready drops for a drawn number of cycles before each word
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(snk_run, snk_quiet);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // every accepted result word against the oldest prediction
    always @(posedge aclk) begin : result_check
        ort_pkg::ort_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_word);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_word.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_word.hit);
                    fail_count++;
                end
                if (m_word.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want.slot_index, m_word.slot_index);
                    fail_count++;
                end
                if (m_word.total_count !== want.total_count) begin
                    $error("total_count: expected %0d, got %0d",
                           want.total_count, m_word.total_count);
                    fail_count++;
                end
                if (m_word.outstanding_count !== want.outstanding_count) begin
                    $error("outstanding_count: expected %0d, got %0d",
                           want.outstanding_count, m_word.outstanding_count);
                    fail_count++;
                end
            end
        end
    end

    // enable is still at its reset value of zero: nothing may change
    task automatic test_disabled_after_reset();
        send_word(ort_pkg::REQ_TRACK, 64'd0, ALL_ONES);
        send_word(ort_pkg::REQ_UPDATE, 64'd0, 64'd5);
        send_word(ort_pkg::REQ_FREE, 64'd0, ALL_ONES);
        send_word(ort_pkg::REQ_REMOVE, ALL_ONES, 64'd0);
        send_word(ort_pkg::REQ_TRACK, ALL_ONES, 64'd0);
        wait_drained();
    endtask

    // each request type with hit and miss, lowest-slot choice, tag extremes
    task automatic test_basic_ops();
        logic [63:0] ta;
        logic [63:0] tf;
        ta = 64'h5a5a_0000_ffff_a5a5;
        tf = 64'h8000_0000_0000_0001;
        // misses on an empty table: outstanding goes negative
        send_word(ort_pkg::REQ_FREE, 64'd0, 64'd0);
        send_word(ort_pkg::REQ_REMOVE, ALL_ONES, ALL_ONES);
        send_word(ort_pkg::REQ_UPDATE, 64'd0, 64'd1);
        send_word(ort_pkg::REQ_TRACK, 64'd0, ALL_ONES);
        send_word(ort_pkg::REQ_TRACK, ALL_ONES, 64'd0);
        send_word(ort_pkg::REQ_TRACK, ta, 64'h1111_2222_3333_4444);
        // duplicate request tag: matches must take the lower slot
        send_word(ort_pkg::REQ_TRACK, ta, 64'h0123_4567_89ab_cdef);
        send_word(ort_pkg::REQ_UPDATE, ta, 64'hdead_beef_0000_0001);
        send_word(ort_pkg::REQ_FREE, 64'd0, 64'hdead_beef_0000_0001);
        send_word(ort_pkg::REQ_UPDATE, ta, 64'hfeed_0000_0000_0002);
        send_word(ort_pkg::REQ_REMOVE, ta, 64'd0);
        send_word(ort_pkg::REQ_REMOVE, ta, 64'd0);
        // freed slot below the top one is claimed again
        send_word(ort_pkg::REQ_TRACK, tf, ~tf);
        send_word(ort_pkg::REQ_FREE, ta, ALL_ONES);
        send_word(ort_pkg::REQ_REMOVE, ALL_ONES, ta);
        send_word(ort_pkg::REQ_FREE, 64'd0, ~tf);
        wait_drained();
    endtask

    // fill every slot, track past full, then empty the table again
    task automatic test_fill_table();
        logic [63:0] rt [ort_pkg::ORT_SLOTS];
        logic [63:0] ht [ort_pkg::ORT_SLOTS];
        for (int i = 0; i < ort_pkg::ORT_SLOTS; i++) begin
            rt[i] = rand64();
            ht[i] = rand64();
            send_word(ort_pkg::REQ_TRACK, rt[i], ht[i]);
        end
        send_word(ort_pkg::REQ_TRACK, rand64(), rand64());
        send_word(ort_pkg::REQ_TRACK, rand64(), rand64());
        for (int i = ort_pkg::ORT_SLOTS - 1; i >= 0; i--) begin
            if (i % 2 == 0)
                send_word(ort_pkg::REQ_FREE, rand64(), ht[i]);
            else
                send_word(ort_pkg::REQ_REMOVE, rt[i], rand64());
        end
        wait_drained();
    endtask

    // disabling keeps the table and counts; they are used again afterwards
    task automatic test_disable_holds();
        logic [63:0] rt [4];
        for (int i = 0; i < 4; i++) begin
            rt[i] = rand64();
            send_word(ort_pkg::REQ_TRACK, rt[i], rand64());
        end
        wait_drained();
        write_enable(1'b0);
        for (int i = 0; i < 8; i++)
            send_word(i[1:0], rt[i % 4], rand64());
        wait_drained();
        write_enable(1'b1);
        for (int i = 0; i < 4; i++)
            send_word(ort_pkg::REQ_REMOVE, rt[i], rand64());
        wait_drained();
    endtask

    // phases of mostly well-formed traffic on live entries, plus noise
    task automatic test_random_traffic();
        int          track_pct;
        int          roll;
        int          s;
        logic [1:0]  kind;
        logic [63:0] rtag;
        logic [63:0] htag;
        for (int p = 0; p < 7; p++) begin
            for (int i = 0; i < 16; i++)
                tag_pool[i] = rand64();
            // one track-heavy phase runs into a full table
            track_pct = (p == 1) ? 75 : 40;
            write_enable((p == 3) ? 1'b0 :
                         ((p == 5) ? 1'($urandom_range(0, 1)) : 1'b1));
            for (int n = 0; n < 180; n++) begin
                roll = $urandom_range(0, 99);
                rtag = ($urandom_range(0, 2) == 0) ? rand64() :
                       tag_pool[4'($urandom_range(0, 15))];
                htag = ($urandom_range(0, 2) == 0) ? rand64() :
                       tag_pool[4'($urandom_range(0, 15))];
                if (roll < 10) begin
                    kind = 2'($urandom_range(0, 3));
                    rtag = rand64();
                    htag = rand64();
                end else if (roll < 10 + track_pct) begin
                    kind = ort_pkg::REQ_TRACK;
                end else begin
                    case ($urandom_range(0, 2))
                        0: kind = ort_pkg::REQ_UPDATE;
                        1: kind = ort_pkg::REQ_FREE;
                        default: kind = ort_pkg::REQ_REMOVE;
                    endcase
                    s = pick_live();
                    if (s >= 0 && $urandom_range(0, 4) != 0) begin
                        if (kind == ort_pkg::REQ_FREE)
                            htag = slot_htag[s];
                        else
                            rtag = slot_rtag[s];
                    end
                end
                send_word(kind, rtag, htag);
            end
            wait_drained();
        end
    endtask

    initial begin : run_tests
        live_slots = '0;
        tracked_total = '0;
        outstanding_now = '0;
        tracking_on = 1'b0;
        // synchronous reset, released on a falling edge
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_disabled_after_reset();
        write_enable(1'b1);
        test_basic_ops();
        test_fill_table();
        test_disable_holds();
        test_random_traffic();

        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ort_pkg.sv
sv/ort_ctrl.sv
sv/ort_dpath.sv
sv/outstanding_request_tracker.sv
tb/tb.sv
